>>> hdl/button_hold_repeat_accelerator_assert.svh
// Assertion macros used by the checker file of the button hold repeat block.
`ifndef BUTTON_HOLD_REPEAT_ACCELERATOR_ASSERT_SVH
`define BUTTON_HOLD_REPEAT_ACCELERATOR_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define BHRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define BHRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bhra_pkg.sv
// Package: types, codes and reset values of the button hold repeat block.
`timescale 1ns / 1ps

package bhra_pkg;

  localparam int CNT_W  = 11;
  localparam int LOOP_W = 4;
  localparam int CFG_AW = 3;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [LOOP_W-1:0] LOOP_MAX = '1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_CHECK,
    PH_HOLD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_REPEAT,
    KIND_MENU,
    KIND_PLAIN
  } kind_t;

  // button indexes
  localparam logic [1:0] KEY_MENU = 2'd0;
  localparam logic [1:0] KEY_UP   = 2'd1;
  localparam logic [1:0] KEY_DOWN = 2'd2;
  localparam logic [1:0] KEY_SET  = 2'd3;

  // event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_LCD_RESET = 3'd5;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DELAY_START = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DELAY_FLOOR = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DELAY_STEP  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LOOPS       = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MENU_TICKS  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MENU_COUNT  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_PLAIN_TICKS = 3'd7;

  // reset values
  localparam logic [CNT_W-1:0]  RST_DEBOUNCE    = 11'd100;
  localparam logic [CNT_W-1:0]  RST_DELAY_START = 11'd300;
  localparam logic [CNT_W-1:0]  RST_DELAY_FLOOR = 11'd50;
  localparam logic [CNT_W-1:0]  RST_DELAY_STEP  = 11'd50;
  localparam logic [LOOP_W-1:0] RST_LOOPS       = 4'd3;
  localparam logic [CNT_W-1:0]  RST_MENU_TICKS  = 11'd1000;
  localparam logic [LOOP_W-1:0] RST_MENU_COUNT  = 4'd5;
  localparam logic [CNT_W-1:0]  RST_PLAIN_TICKS = 11'd100;

endpackage

>>> hdl/button_hold_repeat_accelerator.sv
// Top level: key autorepeat with acceleration, one tick request per cycle without output stalls.
`timescale 1ns / 1ps

// Takes one 1 ms tick request on s_* (pressed-button bits and the
// value-selected flag) and returns exactly one result request on m_* for it:
// an event code (0 none, 1 menu, 2 up, 3 down-right, 4 set, 5 LCD reset) and
// a repeat flag in m_tuser. The result is registered; throughput is one tick
// per cycle without output stalls, set by the single state update that sits
// between the state registers and the result register. Out of reset, s_tready
// is high whenever the result register is empty or being taken in the same
// cycle. Configuration is a plain write port (cfg_we/cfg_addr/cfg_wdata);
// writes take effect at once, a new repeat start delay is picked up at the
// next release. Reset is synchronous; no clearing pass is needed.
module button_hold_repeat_accelerator (
  input  logic                       clk,
  input  logic                       rst,
  // tick request
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [3:0] buttons_pressed, [4] value_selected
  // result request
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [2:0] event_code
  output logic                       m_tuser,   // [0] is_repeat
  // configuration
  input  logic                       cfg_we,
  input  logic [bhra_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bhra_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int CW = bhra_pkg::CNT_W;
  localparam int LW = bhra_pkg::LOOP_W;

  // configuration registers
  logic [CW-1:0] debounce_ticks;
  logic [CW-1:0] delay_start;
  logic [CW-1:0] delay_floor;
  logic [CW-1:0] delay_step;
  logic [LW-1:0] loops_per_level;
  logic [CW-1:0] menu_ticks;
  logic [LW-1:0] menu_reset_count;
  logic [CW-1:0] plain_ticks;

  // hold state
  bhra_pkg::phase_t phase, phase_next;
  bhra_pkg::kind_t  kind, kind_next;
  logic [1:0]       active_button, active_button_next;
  logic [CW-1:0]    wait_counter, wait_counter_next;
  logic [CW-1:0]    current_delay, current_delay_next;
  logic [LW-1:0]    loop_count, loop_count_next;
  logic [LW-1:0]    menu_count, menu_count_next;

  // result
  logic [2:0] event_code, event_code_next;
  logic       is_repeat, is_repeat_next;

  logic [3:0]    buttons;
  logic          selected;
  logic          accept;
  logic          btn_held;
  logic [CW-1:0] wait_inc;
  logic [CW-1:0] iter_len;
  logic          debounce_done;
  logic          iter_done;
  logic [LW-1:0] loop_inc;
  logic [LW-1:0] menu_inc;
  logic [1:0]    first_button;
  logic [CW:0]   floor_plus_step;

  assign buttons  = s_tdata[3:0];
  assign selected = s_tdata[4];
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign btn_held = buttons[active_button];
  assign wait_inc = (wait_counter == bhra_pkg::CNT_MAX) ? wait_counter : wait_counter + 1'b1;
  assign loop_inc = (loop_count == bhra_pkg::LOOP_MAX) ? loop_count : loop_count + 1'b1;
  assign menu_inc = (menu_count == bhra_pkg::LOOP_MAX) ? menu_count : menu_count + 1'b1;
  assign floor_plus_step = {1'b0, delay_floor} + {1'b0, delay_step};

  always_comb begin
    unique case (kind)
      bhra_pkg::KIND_REPEAT: iter_len = current_delay;
      bhra_pkg::KIND_MENU:   iter_len = menu_ticks;
      default:               iter_len = plain_ticks;
    endcase
  end

  assign debounce_done = (wait_inc >= debounce_ticks);
  assign iter_done     = (wait_inc >= iter_len);

  // lowest pressed button wins: menu, up, down-right, set
  always_comb begin
    priority if (buttons[0]) first_button = bhra_pkg::KEY_MENU;
    else if (buttons[1])     first_button = bhra_pkg::KEY_UP;
    else if (buttons[2])     first_button = bhra_pkg::KEY_DOWN;
    else                     first_button = bhra_pkg::KEY_SET;
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      bhra_pkg::PH_IDLE:     if (buttons != 4'd0) phase_next = bhra_pkg::PH_DEBOUNCE;
      bhra_pkg::PH_DEBOUNCE: if (debounce_done) phase_next = bhra_pkg::PH_CHECK;
      bhra_pkg::PH_CHECK:    phase_next = btn_held ? bhra_pkg::PH_HOLD : bhra_pkg::PH_IDLE;
      bhra_pkg::PH_HOLD:     if (iter_done) phase_next = bhra_pkg::PH_CHECK;
      default:               phase_next = bhra_pkg::PH_IDLE;
    endcase
  end

  // counters and result
  always_comb begin
    logic [LW-1:0] loop_upd;
    loop_upd            = loop_count;
    kind_next           = kind;
    active_button_next  = active_button;
    wait_counter_next   = wait_counter;
    current_delay_next  = current_delay;
    loop_count_next     = loop_count;
    menu_count_next     = menu_count;
    event_code_next     = bhra_pkg::EV_NONE;
    is_repeat_next      = 1'b0;
    unique case (phase)
      bhra_pkg::PH_IDLE: begin
        if (buttons != 4'd0) begin
          active_button_next = first_button;
          wait_counter_next  = '0;
        end
      end
      bhra_pkg::PH_DEBOUNCE: begin
        wait_counter_next = wait_inc;
      end
      bhra_pkg::PH_CHECK: begin
        if (btn_held) begin
          if ((active_button == bhra_pkg::KEY_UP || active_button == bhra_pkg::KEY_DOWN)
              && selected)
            kind_next = bhra_pkg::KIND_REPEAT;
          else if (active_button == bhra_pkg::KEY_MENU)
            kind_next = bhra_pkg::KIND_MENU;
          else
            kind_next = bhra_pkg::KIND_PLAIN;
          wait_counter_next = '0;
        end else begin
          // release: report the press and restart the hold counters
          event_code_next    = {1'b0, active_button} + 3'd1;
          loop_count_next    = '0;
          menu_count_next    = '0;
          current_delay_next = delay_start;
        end
      end
      default: begin
        wait_counter_next = wait_inc;
        if (iter_done) begin
          if (kind == bhra_pkg::KIND_REPEAT) begin
            loop_upd = loop_inc;
            if (loop_inc >= loops_per_level) begin
              event_code_next = {1'b0, active_button} + 3'd1;
              is_repeat_next  = 1'b1;
            end
          end else if (kind == bhra_pkg::KIND_MENU) begin
            menu_count_next = menu_inc;
            if (menu_inc >= menu_reset_count) begin
              menu_count_next = '0;
              event_code_next = bhra_pkg::EV_LCD_RESET;
              is_repeat_next  = 1'b1;
            end
          end
          loop_count_next = loop_upd;
          // speed-up toward the floor
          if (kind != bhra_pkg::KIND_PLAIN && loop_upd >= loops_per_level &&
              current_delay > delay_floor) begin
            loop_count_next = '0;
            if ({1'b0, current_delay} < floor_plus_step)
              current_delay_next = delay_floor;
            else
              current_delay_next = current_delay - delay_step;
          end
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bhra_pkg::PH_IDLE;
      kind          <= bhra_pkg::KIND_REPEAT;
      active_button <= '0;
      wait_counter  <= '0;
      current_delay <= bhra_pkg::RST_DELAY_START;
      loop_count    <= '0;
      menu_count    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      kind          <= kind_next;
      active_button <= active_button_next;
      wait_counter  <= wait_counter_next;
      current_delay <= current_delay_next;
      loop_count    <= loop_count_next;
      menu_count    <= menu_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_code <= event_code_next;
      is_repeat  <= is_repeat_next;
    end
  end

  assign m_tdata = {5'd0, event_code};
  assign m_tuser = is_repeat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bhra_pkg::RST_DEBOUNCE;
      delay_start      <= bhra_pkg::RST_DELAY_START;
      delay_floor      <= bhra_pkg::RST_DELAY_FLOOR;
      delay_step       <= bhra_pkg::RST_DELAY_STEP;
      loops_per_level  <= bhra_pkg::RST_LOOPS;
      menu_ticks       <= bhra_pkg::RST_MENU_TICKS;
      menu_reset_count <= bhra_pkg::RST_MENU_COUNT;
      plain_ticks      <= bhra_pkg::RST_PLAIN_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bhra_pkg::REG_DEBOUNCE:    debounce_ticks   <= cfg_wdata;
        bhra_pkg::REG_DELAY_START: delay_start      <= cfg_wdata;
        bhra_pkg::REG_DELAY_FLOOR: delay_floor      <= cfg_wdata;
        bhra_pkg::REG_DELAY_STEP:  delay_step       <= cfg_wdata;
        bhra_pkg::REG_LOOPS:       loops_per_level  <= cfg_wdata[LW-1:0];
        bhra_pkg::REG_MENU_TICKS:  menu_ticks       <= cfg_wdata;
        bhra_pkg::REG_MENU_COUNT:  menu_reset_count <= cfg_wdata[LW-1:0];
        bhra_pkg::REG_PLAIN_TICKS: plain_ticks      <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/bhra_checker.sv
// Port-level checker for the button hold repeat block, bound to the top level.
`timescale 1ns / 1ps
`include "button_hold_repeat_accelerator_assert.svh"

module bhra_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  `BHRA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `BHRA_ASSERT_NEXT(a_one_result, s_tvalid && s_tready, m_tvalid, "accepted tick gave no result")
  `BHRA_ASSERT_NOW(a_ready_free, !s_tready, m_tvalid && !m_tready, "input stalled with free result slot")
  `BHRA_ASSERT_NOW(a_repeat_code, m_tvalid && m_tuser, m_tdata[2:0] != bhra_pkg::EV_NONE, "repeat flag on empty event")
  `BHRA_ASSERT_NOW(a_release_code, m_tvalid && !m_tuser, m_tdata[2:0] != bhra_pkg::EV_LCD_RESET && m_tdata[7:3] == 5'd0, "bad release code")

endmodule

bind button_hold_repeat_accelerator bhra_checker u_bhra_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
